@@ src/vcodec_pkg.sv @@
// Shared types, codes and constants for the varint codec.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vcodec_pkg;

    localparam int WordBits  = 32;
    localparam int ByteBits  = 8;
    localparam int GroupBits = 7;
    localparam int MaxGroups = 5;
    localparam int CountBits = 3;
    localparam int ShiftBits = 5;

    localparam logic [GroupBits-1:0] GroupMask = 7'h7f;

    typedef enum logic
    {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } direction_t;

    typedef struct packed
    {
        logic [WordBits-1:0] word_in;
        logic [ByteBits-1:0] byte_in;
    } in_item_t;

    typedef struct packed
    {
        logic [ByteBits-1:0] byte_out;
        logic                last_byte;
        logic [WordBits-1:0] word_out;
        logic                word_valid;
    } out_item_t;

    typedef enum logic
    {
        ST_IDLE   = 1'b0,
        ST_ENCODE = 1'b1
    } ctrl_state_t;

    typedef struct packed
    {
        logic accept;
        logic load_word;
        logic emit_byte;
        logic dec_step;
        logic cfg_we;
    } ctrl_cmd_t;

    typedef struct packed
    {
        direction_t direction;
        logic       slot_free;
        logic       enc_last;
    } dp_status_t;

endpackage

`default_nettype wire

@@ src/vcodec_ctrl.sv @@
// Controller state machine for the varint codec: request acceptance,
// byte serialization sequencing, config write gating. Uses vcodec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcodec_ctrl
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire                     cfg_valid,
    input  vcodec_pkg::dp_status_t  status,
    output vcodec_pkg::ctrl_cmd_t   cmd,
    output logic                    in_stall,
    output logic                    cfg_ready
);
    import vcodec_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                in_rdy = (status.direction == DIR_ENCODE) || status.slot_free;
            end
            ST_ENCODE:
            begin
                in_rdy = status.slot_free && status.enc_last;
            end
            default:
            begin
                in_rdy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_rdy && status.direction == DIR_ENCODE)
                begin
                    state_next = ST_ENCODE;
                end
            end
            ST_ENCODE:
            begin
                if (status.slot_free && status.enc_last && !in_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = in_valid && in_rdy;
        in_stall      = !in_rdy;
        cfg_ready     = (state_reg == ST_IDLE);
        cmd.cfg_we    = cfg_valid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_word = cmd.accept && (status.direction == DIR_ENCODE);
                cmd.dec_step  = cmd.accept && (status.direction == DIR_DECODE);
            end
            ST_ENCODE:
            begin
                cmd.emit_byte = status.slot_free;
                cmd.load_word = cmd.accept;
            end
            default:
            begin
                cmd.emit_byte = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/vcodec_dp.sv @@
// Datapath for the varint codec: direction register, encode shifter,
// decode accumulator and output register. Uses vcodec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcodec_dp
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  vcodec_pkg::in_item_t    in_data,
    input  wire                     cfg_data,
    input  wire                     out_stall,
    input  vcodec_pkg::ctrl_cmd_t   cmd,
    output vcodec_pkg::dp_status_t  status,
    output logic                    out_valid,
    output vcodec_pkg::out_item_t   out_data
);
    import vcodec_pkg::*;

    direction_t           dir_reg;
    direction_t           dir_next;
    logic [WordBits-1:0]  shift_reg;
    logic [WordBits-1:0]  shift_next;
    logic [CountBits-1:0] enc_cnt_reg;
    logic [CountBits-1:0] enc_cnt_next;
    logic [WordBits-1:0]  acc_reg;
    logic [WordBits-1:0]  acc_next;
    logic [CountBits-1:0] grp_reg;
    logic [CountBits-1:0] grp_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;
    out_item_t            out_data_next;

    logic                 enc_last;
    logic [ShiftBits-1:0] grp_shift;
    logic [WordBits-1:0]  acc_merged;

    assign enc_last = (shift_reg[WordBits-1:GroupBits] == '0)
                   || (enc_cnt_reg == CountBits'(MaxGroups - 1));

    assign grp_shift  = ShiftBits'(grp_reg) * ShiftBits'(GroupBits);
    assign acc_merged = acc_reg
                      | ({{(WordBits-GroupBits){1'b0}}, in_data.byte_in[GroupBits-1:0]}
                         << grp_shift);

    assign status.direction = dir_reg;
    assign status.slot_free = !out_valid_reg || !out_stall;
    assign status.enc_last  = enc_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        dir_next       = dir_reg;
        shift_next     = shift_reg;
        enc_cnt_next   = enc_cnt_reg;
        acc_next       = acc_reg;
        grp_next       = grp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cmd.cfg_we)
        begin
            dir_next = direction_t'(cfg_data);
        end

        if (cmd.emit_byte)
        begin
            out_valid_next           = 1'b1;
            out_data_next            = '0;
            out_data_next.byte_out   = {!enc_last, shift_reg[GroupBits-1:0]};
            out_data_next.last_byte  = enc_last;
            shift_next               = shift_reg >> GroupBits;
            enc_cnt_next             = enc_cnt_reg + 1'b1;
        end

        if (cmd.load_word)
        begin
            shift_next   = in_data.word_in;
            enc_cnt_next = '0;
        end

        if (cmd.dec_step)
        begin
            if (grp_reg < CountBits'(MaxGroups))
            begin
                acc_next = acc_merged;
                grp_next = grp_reg + 1'b1;
            end
            if (!in_data.byte_in[ByteBits-1])
            begin
                out_valid_next           = 1'b1;
                out_data_next            = '0;
                out_data_next.word_out   = acc_next;
                out_data_next.word_valid = 1'b1;
                acc_next                 = '0;
                grp_next                 = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= DIR_ENCODE;
            enc_cnt_reg   <= '0;
            acc_reg       <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dir_reg       <= dir_next;
            enc_cnt_reg   <= enc_cnt_next;
            acc_reg       <= acc_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ src/varint_codec_unit.sv @@
// Top level of the unsigned 32-bit LEB128 varint codec.
// Instantiates vcodec_ctrl and vcodec_dp; types from vcodec_pkg.
//
// In decode mode one byte request is taken per cycle whenever the output
// register is free, and a completed word appears the cycle after its final
// byte. In encode mode a word of n bytes (1 to 5) is serialized by a
// shift register at one byte per cycle while the output is not stalled,
// through a single output register; the next word is taken in the cycle
// the previous word's last byte is registered. The direction register
// may only be written while the block is idle (cfg_ready high).
`timescale 1ns / 1ps
`default_nettype none

module varint_codec_unit
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  vcodec_pkg::in_item_t   in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output vcodec_pkg::out_item_t  out_data,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire                    cfg_data
);
    import vcodec_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    vcodec_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready)
    );

    vcodec_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ src/vcodec_chk.sv @@
// Port-level checker for varint_codec_unit and its bind statement.
// Uses vcodec_pkg types; attached to the top level.
`timescale 1ns / 1ps
`default_nettype none

module vcodec_chk
(
    input wire                    clk,
    input wire                    rst_n,
    input wire                    in_valid,
    input wire                    in_stall,
    input vcodec_pkg::in_item_t   in_data,
    input wire                    out_valid,
    input wire                    out_stall,
    input vcodec_pkg::out_item_t  out_data
);
    import vcodec_pkg::*;

    // stalled input request stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input request changed while stalled");

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output request dropped while stalled");

    a_more_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.word_valid && !out_data.last_byte
        |-> out_data.byte_out[ByteBits-1])
        else $error("non-final encoded byte lacks continuation bit");

    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_byte |-> !out_data.byte_out[ByteBits-1])
        else $error("final encoded byte has continuation bit");

    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.word_valid && out_data.last_byte))
        else $error("result marked as both word and final byte");

endmodule

bind varint_codec_unit vcodec_chk u_vcodec_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

@@ verif/tb_varint_codec_unit.sv @@
// Self-checking testbench for varint_codec_unit: LEB128 encode and decode of 32-bit words.
// Needs vcodec_pkg and the varint_codec_unit RTL. Results are predicted in the bench
// and checked field by field in request order.
`timescale 1ns / 1ps

module tb_varint_codec_unit;

    import vcodec_pkg::*;

    localparam int          WatchdogLimit = 2000;
    localparam int          HoldCycles    = 80;
    localparam int          SettleCycles  = 8;
    localparam logic [7:0]  MoreFlag      = 8'h80;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_item_t  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      in_stall;
    logic      out_valid;
    logic      cfg_ready;
    out_item_t out_data;

    logic      hold_out  = 1'b0;
    bit        jitter    = 1'b1;

    direction_t  mode_now;
    logic [31:0] partial_word;
    int          groups_taken;
    out_item_t   pending[$];

    int mismatches   = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;

    varint_codec_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        if (!jitter)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Bytes of one word, low group first, or the word completed by one byte.
    function automatic void predict_results(input in_item_t item);
        out_item_t   r;
        logic [31:0] rest;
        logic [63:0] merged;
        logic [7:0]  b;
        int          n;
        if (mode_now == DIR_ENCODE)
        begin
            rest = item.word_in;
            n    = 0;
            while (rest > 32'(GroupMask) && n < MaxGroups - 1)
            begin
                r          = '0;
                r.byte_out = MoreFlag | {1'b0, rest[GroupBits-1:0]};
                pending    = {pending, r};
                rest = rest >> GroupBits;
                n++;
            end
            r           = '0;
            r.byte_out  = rest[ByteBits-1:0];
            r.last_byte = 1'b1;
            pending     = {pending, r};
        end
        else
        begin
            b = item.byte_in;
            if (groups_taken < MaxGroups)
            begin
                merged       = {32'b0, partial_word}
                               | (64'(b[GroupBits-1:0]) << (GroupBits * groups_taken));
                partial_word = merged[31:0];
                groups_taken++;
            end
            if ((b & MoreFlag) == 0)
            begin
                r            = '0;
                r.word_out   = partial_word;
                r.word_valid = 1'b1;
                pending      = {pending, r};
                partial_word = '0;
                groups_taken = 0;
            end
        end
    endfunction

    task automatic note_mismatch(input out_item_t want, input out_item_t got, input bit none);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (none)
                $display("unexpected result: byte=%02h last=%0b word=%08h wv=%0b",
                         got.byte_out, got.last_byte, got.word_out, got.word_valid);
            else
                $display({"mismatch: exp byte=%02h last=%0b word=%08h wv=%0b",
                          " | got byte=%02h last=%0b word=%08h wv=%0b"},
                         want.byte_out, want.last_byte, want.word_out, want.word_valid,
                         got.byte_out, got.last_byte, got.word_out, got.word_valid);
        end
    endtask

    // Result checker and output back-pressure.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
                note_mismatch('0, out_data, 1'b1);
            else
            begin
                want = pending.pop_front();
                if (out_data.byte_out !== want.byte_out || out_data.last_byte !== want.last_byte
                    || out_data.word_out !== want.word_out
                    || out_data.word_valid !== want.word_valid)
                    note_mismatch(want, out_data, 1'b0);
            end
        end
        if (hold_out)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            stall_left = idle_len();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_request(input in_item_t item);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        predict_results(item);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_word(input logic [31:0] w);
        in_item_t item;
        item.word_in = w;
        item.byte_in = 8'($urandom_range(0, 255));
        send_request(item);
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t item;
        item.word_in = $urandom;
        item.byte_in = b;
        send_request(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_direction(input direction_t d);
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_now = d;
    endtask

    task automatic send_decode_run();
        int         len;
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            send_byte(8'($urandom_range(0, 255)));
            return;
        end
        len = (r < 85) ? $urandom_range(1, 5) : $urandom_range(6, 8);
        for (int i = 0; i < len; i++)
        begin
            b    = 8'($urandom_range(0, 255));
            b[7] = (i != len - 1);
            send_byte(b);
        end
    endtask

    task automatic test_encode_boundaries();
        logic [31:0] words[$] = '{32'h0, 32'h7f, 32'h80, 32'h3fff, 32'h4000, 32'h1fffff,
                                  32'h200000, 32'hfffffff, 32'h10000000, 32'hffffffff,
                                  32'haaaaaaaa, 32'h55555555};
        write_direction(DIR_ENCODE);
        foreach (words[i])
            send_word(words[i]);
        wait_drained();
    endtask

    task automatic test_decode_boundaries();
        logic [7:0] bytes[$] = '{8'h00, 8'h7f, 8'h80, 8'h01,
                                 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f,
                                 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f,
                                 8'h80, 8'h80, 8'h80, 8'h80, 8'hf0, 8'h00};
        write_direction(DIR_DECODE);
        foreach (bytes[i])
            send_byte(bytes[i]);
        wait_drained();
    endtask

    // Partial decode survives an encode phase.
    task automatic test_mode_switch_keeps_state();
        write_direction(DIR_DECODE);
        send_byte(8'h85);
        wait_drained();
        write_direction(DIR_ENCODE);
        send_word(32'd300);
        send_word($urandom);
        wait_drained();
        write_direction(DIR_DECODE);
        send_byte(8'h03);
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        write_direction(DIR_ENCODE);
        jitter = 1'b0;
        fork
            begin
                hold_out <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_out <= 1'b0;
            end
        join_none
        for (int i = 0; i < 20; i++)
            send_word($urandom >> $urandom_range(0, 32));
        jitter = 1'b1;
        wait_drained();
    endtask

    task automatic test_drain_pause();
        write_direction(DIR_DECODE);
        for (int k = 0; k < 3; k++)
        begin
            repeat (3) send_decode_run();
            wait_drained();
        end
    endtask

    task automatic test_random_mixed();
        for (int phase = 0; phase < 6; phase++)
        begin
            jitter = (phase != 2) && (phase != 3);
            if (phase % 2 == 0)
            begin
                write_direction(DIR_ENCODE);
                for (int i = 0; i < 15; i++)
                    send_word($urandom >> $urandom_range(0, 32));
            end
            else
            begin
                write_direction(DIR_DECODE);
                for (int i = 0; i < 7; i++)
                    send_decode_run();
            end
            wait_drained();
        end
        jitter = 1'b1;
    endtask

    initial
    begin
        mode_now     = DIR_ENCODE;
        partial_word = '0;
        groups_taken = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_boundaries();
        test_decode_boundaries();
        test_mode_switch_keeps_state();
        test_output_holdoff();
        test_drain_pause();
        test_random_mixed();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/vcodec_pkg.sv
src/vcodec_ctrl.sv
src/vcodec_dp.sv
src/varint_codec_unit.sv
src/vcodec_chk.sv
verif/tb_varint_codec_unit.sv
